// ----- hw/rtl/dpc_pkg.sv -----
// Shared types and constants for the DAG path counter.
// Used by the controller, the datapath and the top level.
package dpc_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int MAX_EDGES   = 4096;
    localparam int STACK_DEPTH = 8192;

    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int EDGE_AW = $clog2(MAX_EDGES);
    localparam int PTR_W   = EDGE_AW + 1;
    localparam int STK_AW  = $clog2(STACK_DEPTH);
    localparam int TOP_W   = STK_AW + 1;
    localparam int COUNT_W = 64;
    localparam int MARK_W  = 2;
    localparam int NODE_DW = MARK_W + COUNT_W;
    localparam int EDGE_DW = NODE_W + PTR_W;

    localparam logic [PTR_W-1:0] LIST_END = PTR_W'(MAX_EDGES);

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_COUNT = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd_code;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_OVF  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        MARK_CLEAN = 2'd0,
        MARK_OPEN  = 2'd1,
        MARK_DONE  = 2'd2
    } t_mark;

    typedef enum logic [4:0] {
        S_CLR_HEAD, S_IDLE, S_ADD_RD, S_ADD_WR, S_Q_CLR, S_Q_PUSH, S_POP_RD,
        S_CUR_RD, S_CUR_CHK, S_EDGE_RD, S_EDGE_CHK, S_SUCC_CHK, S_END,
        S_FIN_RD, S_FIN, S_RESP
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_ADD_RD, OP_ADD_WR, OP_CLR_HEAD, OP_Q_CLR, OP_Q_PUSH,
        OP_POP_RD, OP_CUR_RD, OP_CUR_CHK, OP_EDGE_RD, OP_EDGE_CHK, OP_SUCC_CHK,
        OP_END, OP_FIN_RD, OP_FIN, OP_RESP
    } t_op;

    typedef struct packed {
        t_op op;
    } t_ctl;

    typedef struct packed {
        logic sweep_last;
        logic used_full;
        logic top_zero;
        logic top_full;
        logic node_done;
        logic edge_end;
        logic is_target;
        logic all_done;
        logic out_free;
    } t_sts;

endpackage

// ----- hw/rtl/dpc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module dpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/dpc_ctrl.sv -----
// Controller state machine for the DAG path counter.
// Depends on dpc_pkg; drives the datapath through t_ctl, reads t_sts.
module dpc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic [1:0]         i_req_cmd,
    input  dpc_pkg::t_sts      i_sts,
    output dpc_pkg::t_ctl      o_ctl,
    output logic               o_req_ready
);
    import dpc_pkg::*;

    t_state r_state, n_state;
    logic   r_boot, n_boot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR_HEAD;
            r_boot  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_boot  <= n_boot;
        end
    end

    always_comb begin
        n_state = r_state;
        n_boot  = r_boot;
        unique case (r_state)
            S_CLR_HEAD: if (i_sts.sweep_last) begin
                n_state = r_boot ? S_IDLE : S_RESP;
                n_boot  = 1'b0;
            end
            S_IDLE: if (i_req_valid) begin
                unique case (t_cmd_code'(i_req_cmd))
                    CMD_ADD:   n_state = S_ADD_RD;
                    CMD_COUNT: n_state = S_Q_CLR;
                    CMD_CLEAR: n_state = S_CLR_HEAD;
                    default:   n_state = S_RESP;
                endcase
            end
            S_ADD_RD:   n_state = i_sts.used_full ? S_RESP : S_ADD_WR;
            S_ADD_WR:   n_state = S_RESP;
            S_Q_CLR:    if (i_sts.sweep_last) n_state = S_Q_PUSH;
            S_Q_PUSH:   n_state = S_POP_RD;
            S_POP_RD:   n_state = i_sts.top_zero ? S_FIN_RD : S_CUR_RD;
            S_CUR_RD:   n_state = S_CUR_CHK;
            S_CUR_CHK:  n_state = i_sts.node_done ? S_POP_RD : S_EDGE_RD;
            S_EDGE_RD:  n_state = i_sts.edge_end ? S_END : S_EDGE_CHK;
            S_EDGE_CHK: n_state = i_sts.is_target ? S_EDGE_RD : S_SUCC_CHK;
            S_SUCC_CHK: begin
                if (!i_sts.node_done && i_sts.top_full) n_state = S_RESP;
                else                                    n_state = S_EDGE_RD;
            end
            S_END:      n_state = S_POP_RD;
            S_FIN_RD:   n_state = S_FIN;
            S_FIN:      n_state = S_RESP;
            S_RESP:     if (i_sts.out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl.op    = OP_NONE;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_CLR_HEAD: o_ctl.op = OP_CLR_HEAD;
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) o_ctl.op = OP_LOAD;
            end
            S_ADD_RD:   o_ctl.op = OP_ADD_RD;
            S_ADD_WR:   o_ctl.op = OP_ADD_WR;
            S_Q_CLR:    o_ctl.op = OP_Q_CLR;
            S_Q_PUSH:   o_ctl.op = OP_Q_PUSH;
            S_POP_RD:   o_ctl.op = OP_POP_RD;
            S_CUR_RD:   o_ctl.op = OP_CUR_RD;
            S_CUR_CHK:  o_ctl.op = OP_CUR_CHK;
            S_EDGE_RD:  o_ctl.op = OP_EDGE_RD;
            S_EDGE_CHK: o_ctl.op = OP_EDGE_CHK;
            S_SUCC_CHK: o_ctl.op = OP_SUCC_CHK;
            S_END:      o_ctl.op = OP_END;
            S_FIN_RD:   o_ctl.op = OP_FIN_RD;
            S_FIN:      o_ctl.op = OP_FIN;
            S_RESP:     o_ctl.op = OP_RESP;
            default:    o_ctl.op = OP_NONE;
        endcase
    end
endmodule

// ----- hw/rtl/dpc_dp.sv -----
// Datapath for the DAG path counter: edge store, node table, walk stack.
// Depends on dpc_pkg and dpc_ram; steered by dpc_ctrl.
module dpc_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dpc_pkg::t_ctl                i_ctl,
    output dpc_pkg::t_sts                o_sts,
    input  logic [dpc_pkg::NODE_W-1:0]   i_first,
    input  logic [dpc_pkg::NODE_W-1:0]   i_second,
    input  logic [dpc_pkg::NODE_W-1:0]   i_excl,
    input  logic                         i_excl_on,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [dpc_pkg::COUNT_W-1:0]  o_out_count,
    output logic [1:0]                   o_out_status
);
    import dpc_pkg::*;

    logic [NODE_W-1:0]  r_a, r_b, r_x, r_cur, r_s, r_cnt;
    logic               r_xon, r_first, r_all;
    logic [PTR_W-1:0]   r_used, r_edge;
    logic [TOP_W-1:0]   r_top;
    logic [COUNT_W-1:0] r_hit, r_sum, r_count;
    t_status            r_status;
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_count;
    logic [1:0]         r_out_status;

    logic               head_we, node_we, edge_we, stk_we;
    logic [NODE_W-1:0]  head_waddr, head_raddr, node_waddr, node_raddr;
    logic [PTR_W-1:0]   head_wdata, head_rdata;
    logic [NODE_DW-1:0] node_wdata, node_rdata;
    logic [EDGE_DW-1:0] edge_wdata, edge_rdata;
    logic [EDGE_AW-1:0] edge_waddr, edge_raddr;
    logic [STK_AW-1:0]  stk_waddr, stk_raddr;
    logic [NODE_W-1:0]  stk_wdata, stk_rdata;

    logic               node_done, out_load;
    logic [NODE_W-1:0]  e_dest;
    logic [PTR_W-1:0]   e_link;
    logic [COUNT_W-1:0] node_total;

    assign node_done  = t_mark'(node_rdata[NODE_DW-1 -: MARK_W]) == MARK_DONE;
    assign node_total = node_rdata[COUNT_W-1:0];
    assign e_dest     = edge_rdata[EDGE_DW-1 -: NODE_W];
    assign e_link     = edge_rdata[PTR_W-1:0];
    assign out_load   = (i_ctl.op == OP_RESP) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_sts.sweep_last = r_cnt == NODE_W'(MAX_NODES - 1);
        o_sts.used_full  = r_used == PTR_W'(MAX_EDGES);
        o_sts.top_zero   = r_top == '0;
        o_sts.top_full   = r_top == TOP_W'(STACK_DEPTH);
        o_sts.node_done  = node_done;
        o_sts.edge_end   = r_edge[PTR_W-1];
        o_sts.is_target  = e_dest == r_b;
        o_sts.all_done   = r_all;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    always_comb begin
        head_we    = 1'b0;
        head_waddr = r_a;
        head_wdata = r_used;
        head_raddr = r_a;
        node_we    = 1'b0;
        node_waddr = r_cur;
        node_wdata = '0;
        node_raddr = r_a;
        edge_we    = 1'b0;
        edge_waddr = r_used[EDGE_AW-1:0];
        edge_wdata = {r_b, head_rdata};
        edge_raddr = r_edge[EDGE_AW-1:0];
        stk_we     = 1'b0;
        stk_waddr  = r_top[STK_AW-1:0];
        stk_wdata  = r_s;
        stk_raddr  = STK_AW'(r_top - TOP_W'(1));
        case (i_ctl.op)
            OP_CLR_HEAD: begin
                head_we    = 1'b1;
                head_waddr = r_cnt;
                head_wdata = LIST_END;
            end
            OP_ADD_WR: begin
                head_we = 1'b1;
                edge_we = 1'b1;
            end
            OP_Q_CLR: begin
                node_we    = 1'b1;
                node_waddr = r_cnt;
                node_wdata = {((r_xon && r_cnt == r_x) ? MARK_DONE : MARK_CLEAN),
                              {COUNT_W{1'b0}}};
            end
            OP_Q_PUSH: begin
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = r_a;
            end
            OP_CUR_RD: begin
                node_raddr = stk_rdata;
                head_raddr = stk_rdata;
            end
            OP_EDGE_CHK: node_raddr = e_dest;
            OP_SUCC_CHK: stk_we = !node_done && !o_sts.top_full;
            OP_END: begin
                node_we    = 1'b1;
                node_wdata = r_all ? {MARK_DONE, r_hit + r_sum} : {MARK_OPEN, r_hit};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_LOAD: begin
                r_a      <= i_first;
                r_b      <= i_second;
                r_x      <= i_excl;
                r_xon    <= i_excl_on;
                r_count  <= '0;
                r_status <= ST_OK;
            end
            OP_ADD_RD: if (o_sts.used_full) r_status <= ST_FULL;
            OP_CUR_RD: r_cur <= stk_rdata;
            OP_CUR_CHK: begin
                r_first <= t_mark'(node_rdata[NODE_DW-1 -: MARK_W]) == MARK_CLEAN;
                r_edge  <= head_rdata;
                r_hit   <= node_total;
                r_sum   <= '0;
                r_all   <= 1'b1;
            end
            OP_EDGE_CHK: begin
                r_edge <= e_link;
                r_s    <= e_dest;
                if (o_sts.is_target && r_first) r_hit <= r_hit + COUNT_W'(1);
            end
            OP_SUCC_CHK: begin
                if (node_done) begin
                    r_sum <= r_sum + node_total;
                end else begin
                    r_all <= 1'b0;
                    if (o_sts.top_full) r_status <= ST_OVF;
                end
            end
            OP_FIN: r_count <= node_total;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_used      <= '0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_ctl.op)
                OP_CLR_HEAD: begin
                    r_cnt  <= r_cnt + NODE_W'(1);
                    r_used <= '0;
                end
                OP_LOAD:   r_cnt <= '0;
                OP_Q_CLR:  r_cnt <= r_cnt + NODE_W'(1);
                OP_ADD_WR: r_used <= r_used + PTR_W'(1);
                OP_Q_PUSH: r_top <= TOP_W'(1);
                OP_CUR_CHK: if (node_done) r_top <= r_top - TOP_W'(1);
                OP_SUCC_CHK: begin
                    if (!node_done) begin
                        if (o_sts.top_full) r_top <= '0;
                        else                r_top <= r_top + TOP_W'(1);
                    end
                end
                OP_END: if (r_all) r_top <= r_top - TOP_W'(1);
                default: ;
            endcase
            if (out_load)         r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_count  <= (r_status == ST_OK) ? r_count : '0;
            r_out_status <= r_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_count  = r_out_count;
    assign o_out_status = r_out_status;

    dpc_ram #(.WIDTH(PTR_W), .DEPTH(MAX_NODES)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_waddr), .i_wdata(head_wdata),
        .i_raddr(head_raddr), .o_rdata(head_rdata)
    );

    dpc_ram #(.WIDTH(EDGE_DW), .DEPTH(MAX_EDGES)) u_edge (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(edge_waddr), .i_wdata(edge_wdata),
        .i_raddr(edge_raddr), .o_rdata(edge_rdata)
    );

    dpc_ram #(.WIDTH(NODE_DW), .DEPTH(MAX_NODES)) u_node (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_waddr), .i_wdata(node_wdata),
        .i_raddr(node_raddr), .o_rdata(node_rdata)
    );

    dpc_ram #(.WIDTH(NODE_W), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );
endmodule

// ----- hw/rtl/dag_path_counter.sv -----
// Top level: registers one result per request; a count query walks the graph from the
// first node, expanding nodes, popping finished nodes and scanning their edges.
// One request at a time; the next is taken the cycle after the result is registered,
// which waits while the output register is still held.
// Synchronous active-low reset; the edge-list heads are then swept before the first
// request is taken. Depends on dpc_pkg, dpc_ctrl, dpc_dp.
module dag_path_counter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // first_node, second_node, exclude_node, exclusion_on
    input  logic [1:0]  i_s_axis_tuser,   // command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // path_count
    output logic [1:0]  o_m_axis_tuser    // status
);
    import dpc_pkg::*;

    t_ctl ctl;
    t_sts sts;

    dpc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_s_axis_tvalid), .i_req_cmd(i_s_axis_tuser),
        .i_sts(sts), .o_ctl(ctl), .o_req_ready(o_s_axis_tready)
    );

    dpc_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .o_sts(sts),
        .i_first(i_s_axis_tdata[9:0]),
        .i_second(i_s_axis_tdata[19:10]),
        .i_excl(i_s_axis_tdata[29:20]),
        .i_excl_on(i_s_axis_tdata[30]),
        .i_out_ready(i_m_axis_tready),
        .o_out_valid(o_m_axis_tvalid),
        .o_out_count(o_m_axis_tdata),
        .o_out_status(o_m_axis_tuser)
    );
endmodule
